// ===== design/rqd_pkg.sv =====
// ----------------------------------------------------------------------------
// rqd_pkg: shared definitions of the requantized rounded division block
// Register indexes, widths and the slot record that moves down the
// divider's chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none
package rqd_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned WideWidth = 64;
   localparam int unsigned AddrWidth = 5;

   localparam logic [2:0] REG_DELTA = 3'd0;
   localparam logic [2:0] REG_EPS   = 3'd1;
   localparam logic [2:0] REG_ETA   = 3'd2;
   localparam logic [2:0] REG_MUL   = 3'd3;
   localparam logic [2:0] REG_ADD   = 3'd4;
   localparam logic [2:0] REG_SHIFT = 3'd5;

   localparam logic signed [31:0] ClampLow  = -32'sd128;
   localparam logic signed [31:0] ClampHigh = 32'sd127;

   // One item as it passes through the restoring divider.
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic                 zero;
      logic                 neg;
      logic [WideWidth-1:0] rem;
      logic [WideWidth-1:0] dq;
      logic [WideWidth-1:0] divisor;
   } div_slot_type;

endpackage
`default_nettype wire

// ===== design/rqd_div_cell.sv =====
// ----------------------------------------------------------------------------
// rqd_div_cell: one step of the restoring divider
// Takes one dividend bit into the partial remainder, compares against the
// divisor, shifts in one quotient bit and registers the slot for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rqd_div_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  rqd_pkg::div_slot_type      slot_in,
   output rqd_pkg::div_slot_type      slot_out
);
   import rqd_pkg::*;

   div_slot_type           slot_ff;
   div_slot_type           slot_in_c;
   logic [WideWidth-1:0]   shifted;
   logic                   fits;

   always_comb begin
      // For a nonzero divisor the remainder stays below the divisor, so its top bit is always clear.
      shifted   = {slot_in.rem[WideWidth-2:0], slot_in.dq[WideWidth-1]};
      fits      = (shifted >= slot_in.divisor);
      slot_in_c = slot_in;
      slot_in_c.rem = fits ? (shifted - slot_in.divisor) : shifted;
      slot_in_c.dq  = {slot_in.dq[WideWidth-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in_c.valid;
      end
      slot_ff.last    <= slot_in_c.last;
      slot_ff.zero    <= slot_in_c.zero;
      slot_ff.neg     <= slot_in_c.neg;
      slot_ff.rem     <= slot_in_c.rem;
      slot_ff.dq      <= slot_in_c.dq;
      slot_ff.divisor <= slot_in_c.divisor;
   end

   assign slot_out = slot_ff;
endmodule
`default_nettype wire

// ===== design/rqd_requant.sv =====
// ----------------------------------------------------------------------------
// rqd_requant: requantization of the divider's quotient
// Restores the sign, multiplies, adds the offset and rounding term, shifts
// arithmetically and clamps to int8; the shift and the clamp share the last stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rqd_requant (
   input  wire                        clock,
   input  wire                        reset,
   input  rqd_pkg::div_slot_type      slot_in,
   input  wire  [31:0]                mul_cfg,
   input  wire  [31:0]                add_cfg,
   input  wire  [4:0]                 shift_cfg,
   output logic                       valid_out,
   output logic [7:0]                 quotient_out,
   output logic                       zero_out,
   output logic                       last_out
);
   import rqd_pkg::*;

   logic [3:0]             valid_ff;
   logic [3:0]             zero_ff;
   logic [3:0]             last_ff;
   logic [WordWidth-1:0]   q_ff;
   logic [WordWidth-1:0]   prod_ff;
   logic [WordWidth-1:0]   t_ff;
   logic [7:0]             res_ff;
   logic [WordWidth-1:0]   q_in;
   logic [WideWidth-1:0]   prod_wide;
   logic [WordWidth-1:0]   rnd;
   logic signed [WordWidth-1:0] r;
   logic [7:0]             res_in;

   always_comb begin
      q_in      = slot_in.neg ? (32'd0 - slot_in.dq[WordWidth-1:0])
                              : slot_in.dq[WordWidth-1:0];
      prod_wide = q_ff * mul_cfg;
      rnd       = (shift_cfg == 5'd0) ? 32'd0 : (32'd1 << (shift_cfg - 5'd1));
      r         = $signed(t_ff) >>> shift_cfg;
      if (zero_ff[2]) begin
         res_in = 8'd0;
      end else if (r < ClampLow) begin
         res_in = ClampLow[7:0];
      end else if (r > ClampHigh) begin
         res_in = ClampHigh[7:0];
      end else begin
         res_in = r[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 4'd0;
      end else begin
         valid_ff <= {valid_ff[2:0], slot_in.valid};
      end
      zero_ff <= {zero_ff[2:0], slot_in.zero};
      last_ff <= {last_ff[2:0], slot_in.last};
      q_ff    <= q_in;
      prod_ff <= prod_wide[WordWidth-1:0];
      t_ff    <= prod_ff + add_cfg + rnd;
      res_ff  <= res_in;
   end

   assign valid_out    = valid_ff[3];
   assign quotient_out = res_ff;
   assign zero_out     = zero_ff[3];
   assign last_out     = last_ff[3];
endmodule
`default_nettype wire

// ===== design/requantized_rounded_division.sv =====
// ----------------------------------------------------------------------------
// requantized_rounded_division: pipelined int8 requantized rounded divider
// Scales numerator and denominator, divides with rounding half away from
// zero in a chain of 64 divider cells, then requantizes and clamps to int8.
// ----------------------------------------------------------------------------
// Usage:
// An item (numerator, denominator, last flag) is taken at a rising edge
// where start is high and busy is low. One item can be taken every cycle while busy is low.
// Every item produces exactly one result, shown on the rsp_ ports for one
// cycle with rsp_valid high. The pipeline holds the four scaling stages, the
// 64 cells of the restoring divider (one quotient bit per cell) and four
// requantization stages. Results appear in item order. The receiver cannot
// stall the block. The user must write the registers through the APB port
// only while the block is idle; the block does not enforce this. The product
// of delta and eta is held in its own register; busy is high in the
// cycle after a write so that it has settled before the next item enters.
// Reset empties the pipeline and loads the register defaults.
// A zero scaled denominator returns 0 with rsp_divide_by_zero set.
// ----------------------------------------------------------------------------
`default_nettype none
module requantized_rounded_division (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [31:0]                  req_numerator,
   input  wire  [31:0]                  req_denominator,
   input  wire                          req_last_in,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_quotient_int8,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_last_out,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire  [rqd_pkg::AddrWidth-1:0] paddr,
   input  wire  [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import rqd_pkg::*;

   localparam int unsigned Cells = WideWidth;

   // Configuration registers.
   logic [31:0] delta_ff, eps_ff, eta_ff, mul_ff, add_ff;
   logic [4:0]  shift_ff;
   logic [31:0] nscale_ff;
   logic        hold_ff;
   logic        cfg_write;
   logic [2:0]  reg_index;
   logic [WideWidth-1:0] nscale_wide;

   assign pready    = 1'b1;
   assign reg_index = paddr[AddrWidth-1:2];
   assign cfg_write = psel & penable & pwrite;
   assign busy      = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= 32'd1;
         eps_ff   <= 32'd0;
         eta_ff   <= 32'd1;
         mul_ff   <= 32'd1;
         add_ff   <= 32'd0;
         shift_ff <= 5'd1;
         hold_ff  <= 1'b0;
      end else begin
         hold_ff <= cfg_write;
         if (cfg_write) begin
            unique case (reg_index)
               REG_DELTA: delta_ff <= pwdata;
               REG_EPS:   eps_ff   <= pwdata;
               REG_ETA:   eta_ff   <= pwdata;
               REG_MUL:   mul_ff   <= pwdata;
               REG_ADD:   add_ff   <= pwdata;
               REG_SHIFT: shift_ff <= pwdata[4:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DELTA: prdata = delta_ff;
         REG_EPS:   prdata = eps_ff;
         REG_ETA:   prdata = eta_ff;
         REG_MUL:   prdata = mul_ff;
         REG_ADD:   prdata = add_ff;
         REG_SHIFT: prdata = {27'd0, shift_ff};
         default:   prdata = 32'd0;
      endcase
   end

   // The numerator scale only wraps to 32 bits, so it is precomputed.
   assign nscale_wide = delta_ff * eta_ff;
   always_ff @(posedge clock) begin
      nscale_ff <= nscale_wide[WordWidth-1:0];
   end

   // Front stages: products, offset add, magnitudes, rounded dividend.
   logic [3:0]            fv_ff, fl_ff;
   logic signed [63:0]    pn_ff, pd_ff, num_ff, den_ff;
   logic [63:0]           an_ff, ad_ff, dividend_ff, divisor_ff;
   logic                  neg3_ff, zero3_ff, neg4_ff, zero4_ff;
   logic                  accept;
   logic signed [63:0]    pn_in, pd_in;

   assign accept = start & ~hold_ff;
   assign pn_in  = $signed(nscale_ff) * $signed(req_numerator);
   assign pd_in  = $signed(eta_ff) * $signed(req_denominator);

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 4'd0;
      end else begin
         fv_ff <= {fv_ff[2:0], accept};
      end
      fl_ff       <= {fl_ff[2:0], req_last_in};
      pn_ff       <= pn_in;
      pd_ff       <= pd_in;
      num_ff      <= pn_ff;
      den_ff      <= pd_ff + {{32{eps_ff[31]}}, eps_ff};
      an_ff       <= num_ff[63] ? (64'd0 - num_ff) : num_ff;
      ad_ff       <= den_ff[63] ? (64'd0 - den_ff) : den_ff;
      neg3_ff     <= num_ff[63] ^ den_ff[63];
      zero3_ff    <= (den_ff == 64'sd0);
      // Adding half the divisor turns the truncating divide into rounding.
      dividend_ff <= an_ff + {1'b0, ad_ff[63:1]};
      divisor_ff  <= ad_ff;
      neg4_ff     <= neg3_ff;
      zero4_ff    <= zero3_ff;
   end

   // Chain of divider cells, one quotient bit per cell.
   div_slot_type slots [Cells+1];

   always_comb begin
      slots[0].valid   = fv_ff[3];
      slots[0].last    = fl_ff[3];
      slots[0].zero    = zero4_ff;
      slots[0].neg     = neg4_ff;
      slots[0].rem     = 64'd0;
      slots[0].dq      = dividend_ff;
      slots[0].divisor = divisor_ff;
   end

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      rqd_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .slot_in  (slots[i]),
         .slot_out (slots[i+1])
      );
   end

   // Requantization and clamp.
   rqd_requant u_requant (
      .clock        (clock),
      .reset        (reset),
      .slot_in      (slots[Cells]),
      .mul_cfg      (mul_ff),
      .add_cfg      (add_ff),
      .shift_cfg    (shift_ff),
      .valid_out    (rsp_valid),
      .quotient_out (rsp_quotient_int8),
      .zero_out     (rsp_divide_by_zero),
      .last_out     (rsp_last_out)
   );
endmodule
`default_nettype wire
